// ===== rtl/fxa_pkg.sv =====
// Package for the fixed-point ALU: commands, status codes, widths and
// the divider step and saturation helpers. Depends on nothing.
package fxa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int NUM_W     = 32 + FRAC_BITS;
	localparam int DIV_STAGES = NUM_W;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
		CMD_LT = 4'd4, CMD_GT = 4'd5, CMD_LE = 4'd6, CMD_GE = 4'd7,
		CMD_EQ = 4'd8, CMD_NE = 4'd9, CMD_INC = 4'd10, CMD_DEC = 4'd11,
		CMD_MIN = 4'd12, CMD_MAX = 4'd13, CMD_FROM_INT = 4'd14, CMD_TO_INT = 4'd15
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_SAT = 2'd1, ST_DIVZERO = 2'd2
	} status_t;

	// result fields travelling beside the divider
	typedef struct packed {
		cmd_t             cmd;
		logic [31:0]      res;
		logic             truth;
		status_t          status;
	} side_t;

	typedef struct packed {
		logic             neg;
		logic             zero;
		logic [31:0]      den;
		logic [32:0]      rem;
		logic [NUM_W-1:0] rq;
	} div_t;

	// one restoring step: shift the next numerator bit in, subtract if it fits
	function automatic div_t div_step(div_t d);
		div_t        o;
		logic [32:0] t;
		logic        fits;
		o    = d;
		t    = {d.rem[31:0], d.rq[NUM_W-1]};
		fits = (t >= {1'b0, d.den});
		o.rem = fits ? t - {1'b0, d.den} : t;
		o.rq  = {d.rq[NUM_W-2:0], fits};
		return o;
	endfunction

	// apply sign to a magnitude and clamp; top bit flags saturation
	function automatic logic [32:0] clamp_mag(logic [63:0] m, logic neg);
		logic [32:0] o;
		if (neg) begin
			if (m > 64'h0000_0000_8000_0000) o = {1'b1, 32'h8000_0000};
			else o = {1'b0, 32'(~m + 64'd1)};
		end else begin
			if (m > 64'h0000_0000_7FFF_FFFF) o = {1'b1, 32'h7FFF_FFFF};
			else o = {1'b0, m[31:0]};
		end
		return o;
	endfunction

endpackage

// ===== rtl/fxa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side
// channel of result fields kept in step. Depends on fxa_pkg.
module fxa_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  fxa_pkg::div_t  in_div,
	input  fxa_pkg::side_t in_side,
	output logic          out_valid,
	output fxa_pkg::div_t  out_div,
	output fxa_pkg::side_t out_side
);
	import fxa_pkg::*;

	logic  valid_s [DIV_STAGES];
	div_t  div_s   [DIV_STAGES];
	side_t side_s  [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) valid_s[i] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int i = 1; i < DIV_STAGES; i++) valid_s[i] <= valid_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0]  <= div_step(in_div);
			side_s[0] <= in_side;
			for (int i = 1; i < DIV_STAGES; i++) begin
				div_s[i]  <= div_step(div_s[i-1]);
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_div   = div_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule

// ===== rtl/fixed_point_alu.sv =====
// Top level of the signed fixed-point ALU: input stages, multiplier,
// divider pipeline and output register. Depends on fxa_pkg and fxa_div.
//
//  channel | handshake          | fields
//  input   | in_valid, in_stall | cmd, operand_a, operand_b
//  output  | out_valid,out_stall| result, truth, status
//
// Every item passes through stages 1 to 3, the divider pipeline and the
// output register; the divider, one quotient bit per stage, sets the depth.
// One item enters per cycle unless the output stalls; a stall while out_valid is high freezes the whole pipeline.
// Reset clears the valid bits only.
module fixed_point_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         cmd,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result,
	output logic               truth,
	output logic [1:0]         status
);
	import fxa_pkg::*;

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: capture operands
	logic               valid_s1;
	cmd_t               cmd_s1;
	logic signed [31:0] a_s1, b_s1;

	// stage 2: simple ops, product, magnitudes
	logic               valid_s2;
	side_t              side_s2;
	logic signed [63:0] prod_s2;
	logic [31:0]        mag_a_s2, mag_b_s2;
	logic               neg_s2, zero_s2;

	// stage 3: multiply rounding, divider set-up
	logic  valid_s3;
	side_t side_s3;
	div_t  div_s3;

	logic  dv_valid;
	div_t  dv_div;
	side_t dv_side;

	logic [31:0] result_q;
	logic        truth_q;
	status_t     status_q;
	logic        valid_q;

	// simple results from stage 1
	side_t              side_c;
	logic signed [32:0] sum_c, dif_c, inc_c, dec_c;
	logic signed [63:0] shl_c;
	logic               lt_c, eq_c;

	always_comb begin
		sum_c = 33'(a_s1) + 33'(b_s1);
		dif_c = 33'(a_s1) - 33'(b_s1);
		inc_c = 33'(a_s1) + 33'sd1;
		dec_c = 33'(a_s1) - 33'sd1;
		shl_c = 64'(a_s1) <<< FRAC_BITS;
		lt_c  = a_s1 < b_s1;
		eq_c  = a_s1 == b_s1;
		side_c.cmd    = cmd_s1;
		side_c.res    = '0;
		side_c.truth  = 1'b0;
		side_c.status = ST_OK;
		case (cmd_s1)
			CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
				logic signed [32:0] v;
				case (cmd_s1)
					CMD_ADD: v = sum_c;
					CMD_SUB: v = dif_c;
					CMD_INC: v = inc_c;
					default: v = dec_c;
				endcase
				if (v[32] != v[31]) begin
					side_c.res    = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
					side_c.status = ST_SAT;
				end else begin
					side_c.res = v[31:0];
				end
			end
			CMD_LT: side_c.truth = lt_c;
			CMD_GT: side_c.truth = !lt_c && !eq_c;
			CMD_LE: side_c.truth = lt_c || eq_c;
			CMD_GE: side_c.truth = !lt_c;
			CMD_EQ: side_c.truth = eq_c;
			CMD_NE: side_c.truth = !eq_c;
			CMD_MIN: side_c.res = lt_c ? a_s1 : b_s1;
			CMD_MAX: side_c.res = lt_c ? b_s1 : a_s1;
			CMD_FROM_INT: begin
				if (shl_c > 64'sh7FFF_FFFF) begin
					side_c.res = 32'h7FFF_FFFF; side_c.status = ST_SAT;
				end else if (shl_c < -64'sh8000_0000) begin
					side_c.res = 32'h8000_0000; side_c.status = ST_SAT;
				end else begin
					side_c.res = shl_c[31:0];
				end
			end
			CMD_TO_INT: side_c.res = a_s1 >>> FRAC_BITS;
			default: side_c.res = '0;
		endcase
	end

	// multiply rounding at stage 3
	logic [63:0] pmag_c, pm_c;
	logic [32:0] pcl_c;
	side_t       side3_c;
	div_t        div3_c;

	always_comb begin
		pmag_c  = prod_s2[63] ? 64'(-prod_s2) : 64'(prod_s2);
		pm_c    = (pmag_c + 64'((64'd1 << FRAC_BITS) >> 1)) >> FRAC_BITS;
		pcl_c   = clamp_mag(pm_c, prod_s2[63]);
		side3_c = side_s2;
		if (side_s2.cmd == CMD_MUL) begin
			side3_c.res    = pcl_c[31:0];
			side3_c.status = pcl_c[32] ? ST_SAT : ST_OK;
		end
		div3_c.neg  = neg_s2;
		div3_c.zero = zero_s2;
		div3_c.den  = mag_b_s2;
		div3_c.rem  = '0;
		div3_c.rq   = {mag_a_s2, {FRAC_BITS{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_q  <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1   <= cmd_t'(cmd);
			a_s1     <= operand_a;
			b_s1     <= operand_b;
			side_s2  <= side_c;
			prod_s2  <= a_s1 * b_s1;
			mag_a_s2 <= a_s1[31] ? 32'(-a_s1) : a_s1;
			mag_b_s2 <= b_s1[31] ? 32'(-b_s1) : b_s1;
			neg_s2   <= a_s1[31] ^ b_s1[31];
			zero_s2  <= b_s1 == 32'sd0;
			side_s3  <= side3_c;
			div_s3   <= div3_c;
		end
	end

	fxa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s3),
		.in_div   (div_s3),
		.in_side  (side_s3),
		.out_valid(dv_valid),
		.out_div  (dv_div),
		.out_side (dv_side)
	);

	// divide finish: round half up on the remainder, then sign and clamp
	logic [NUM_W:0] dm_c;
	logic [32:0]    dcl_c;

	always_comb begin
		dm_c  = {1'b0, dv_div.rq} +
			(NUM_W+1)'({dv_div.rem, 1'b0} >= {2'b00, dv_div.den});
		dcl_c = clamp_mag(64'(dm_c), dv_div.neg);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= dv_side.res;
			truth_q  <= dv_side.truth;
			status_q <= dv_side.status;
			if (dv_side.cmd == CMD_DIV) begin
				if (dv_div.zero) begin
					result_q <= '0;
					status_q <= ST_DIVZERO;
				end else begin
					result_q <= dcl_c[31:0];
					status_q <= dcl_c[32] ? ST_SAT : ST_OK;
				end
			end
		end
	end

	assign out_valid = valid_q;
	assign result    = result_q;
	assign truth     = truth_q;
	assign status    = status_q;

	a_divzero_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIVZERO |-> result == 32'd0)
		else $error("divide by zero with non-zero result");
	a_truth_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truth |-> result == 32'd0 && status == ST_OK)
		else $error("comparison result carries data");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(status))
		else $error("output changed under stall");
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not tied to output stall");

endmodule

// ===== verif/tb_fixed_point_alu.sv =====
// Testbench for the fixed-point ALU: directed table then random items, each
// result checked against an in-bench predictor or a typed-in table value. Depends on fxa_pkg and the RTL.
module tb_fixed_point_alu;
	timeunit 1ns;
	timeprecision 1ps;
	import fxa_pkg::*;

	localparam int N_RANDOM   = 1500;
	localparam int CYCLE_CAP  = 400000;
	localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
	localparam logic [31:0] MINW = 32'h8000_0000;

	typedef struct {
		logic [31:0] res;
		logic        truth;
		status_t     status;
	} alu_out_t;

	typedef struct {
		cmd_t        op;
		logic [31:0] a;
		logic [31:0] b;
		logic        known;
		alu_out_t    want;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] cmd = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] result;
	logic truth;
	logic [1:0] status;

	alu_out_t pending[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;

	fixed_point_alu u_top (.*);

	always #6 clk = ~clk;

	function automatic alu_out_t sat64(longint v);
		alu_out_t o;
		o.truth = 1'b0;
		o.status = ST_OK;
		if (v > 64'sd2147483647) begin
			o.res = MAXW; o.status = ST_SAT;
		end else if (v < -64'sd2147483648) begin
			o.res = MINW; o.status = ST_SAT;
		end else o.res = v[31:0];
		return o;
	endfunction

	function automatic alu_out_t alu_predict(cmd_t op, logic [31:0] ra, logic [31:0] rb);
		longint a, b, p, m, num, den;
		alu_out_t o;
		a = longint'($signed(ra));
		b = longint'($signed(rb));
		o.res = '0; o.truth = 1'b0; o.status = ST_OK;
		case (op)
			CMD_ADD: o = sat64(a + b);
			CMD_SUB: o = sat64(a - b);
			CMD_MUL: begin
				p = a * b;
				m = ((p < 0 ? -p : p) + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
				o = sat64(p < 0 ? -m : m);
			end
			CMD_DIV: begin
				if (b == 0) o.status = ST_DIVZERO;
				else begin
					num = (a < 0 ? -a : a) << FRAC_BITS;
					den = b < 0 ? -b : b;
					m = (2 * num + den) / (2 * den);
					o = sat64(((a < 0) != (b < 0)) ? -m : m);
				end
			end
			CMD_LT: o.truth = a < b;
			CMD_GT: o.truth = a > b;
			CMD_LE: o.truth = a <= b;
			CMD_GE: o.truth = a >= b;
			CMD_EQ: o.truth = a == b;
			CMD_NE: o.truth = a != b;
			CMD_INC: o = sat64(a + 1);
			CMD_DEC: o = sat64(a - 1);
			CMD_MIN: o.res = a < b ? ra : rb;
			CMD_MAX: o.res = a > b ? ra : rb;
			CMD_FROM_INT: o = sat64(a * (64'sd1 << FRAC_BITS));
			default: o.res = 32'(a >>> FRAC_BITS);
		endcase
		return o;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return MAXW - $urandom_range(0, 3);
			1: return MINW + $urandom_range(0, 3);
			2: return 32'($signed($urandom_range(0, 1024)) - 512);
			3: return $urandom_range(0, 1) ? 32'h0 : 32'h100;
			4: return 32'($urandom) >>> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	// random receiver stalls in bursts
	always @(negedge clk) begin
		int burst;
		if (!quiet && !out_stall && $urandom_range(0, 9) == 0) begin
			burst = $urandom_range(1, 7);
			out_stall <= 1'b1;
			repeat (burst) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		alu_out_t w;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$display("%0t unexpected item res=%h truth=%b st=%0d", $time, result, truth,
					status);
				errors++;
			end else begin
				w = pending.pop_front();
				if (result !== w.res || truth !== w.truth || status !== w.status) begin
					$display("%0t exp res=%h truth=%b st=%0d act res=%h truth=%b st=%0d",
						$time, w.res, w.truth, w.status, result, truth, status);
					errors++;
				end
			end
		end
		if (cycles > CYCLE_CAP) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_item(cmd_t op, logic [31:0] a, logic [31:0] b, bit gaps);
		int gap;
		if (gaps && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		operand_a <= a;
		operand_b <= b;
		// hold until accepted
		do @(posedge clk); while (in_stall);
		pending.push_back(alu_predict(op, a, b));
		@(negedge clk);
	endtask

	vec_t dir_tab[$];

	task automatic add_vec(cmd_t op, logic [31:0] a, logic [31:0] b, bit kn,
			logic [31:0] r = 0, logic t = 0, status_t s = ST_OK);
		vec_t v;
		v.op = op; v.a = a; v.b = b; v.known = kn;
		v.want.res = r; v.want.truth = t; v.want.status = s;
		dir_tab.push_back(v);
	endtask

	initial begin
		alu_out_t got;
		add_vec(CMD_ADD, MAXW, 32'd1, 1, MAXW, 0, ST_SAT);
		add_vec(CMD_SUB, MINW, 32'd1, 1, MINW, 0, ST_SAT);
		add_vec(CMD_MUL, MAXW, MAXW, 1, MAXW, 0, ST_SAT);
		add_vec(CMD_MUL, MINW, MAXW, 1, MINW, 0, ST_SAT);
		add_vec(CMD_MUL, 32'h0000_0180, 32'hFFFF_FF80, 0);
		add_vec(CMD_MUL, 32'h0000_0001, 32'h0000_0080, 0);
		add_vec(CMD_DIV, 32'h0000_1234, 32'h0, 1, 32'h0, 0, ST_DIVZERO);
		add_vec(CMD_DIV, MINW, 32'hFFFF_FFFF, 1, MAXW, 0, ST_SAT);
		add_vec(CMD_DIV, 32'h0000_0001, 32'h0000_0003, 0);
		add_vec(CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0200, 0);
		add_vec(CMD_LT, MINW, MAXW, 1, 0, 1, ST_OK);
		add_vec(CMD_GT, MINW, MAXW, 1, 0, 0, ST_OK);
		add_vec(CMD_LE, 32'h5, 32'h5, 1, 0, 1, ST_OK);
		add_vec(CMD_GE, 32'hFFFF_FFFE, 32'h5, 1, 0, 0, ST_OK);
		add_vec(CMD_EQ, MAXW, MAXW, 1, 0, 1, ST_OK);
		add_vec(CMD_NE, MAXW, MAXW, 1, 0, 0, ST_OK);
		add_vec(CMD_INC, MAXW, 32'h0, 1, MAXW, 0, ST_SAT);
		add_vec(CMD_DEC, MINW, 32'hFFFF_FFFF, 1, MINW, 0, ST_SAT);
		add_vec(CMD_MIN, 32'h7, 32'h7, 1, 32'h7, 0, ST_OK);
		add_vec(CMD_MAX, MINW, MAXW, 1, MAXW, 0, ST_OK);
		add_vec(CMD_FROM_INT, MAXW, 32'h0, 1, MAXW, 0, ST_SAT);
		add_vec(CMD_FROM_INT, MINW, 32'h0, 1, MINW, 0, ST_SAT);
		add_vec(CMD_TO_INT, MINW, 32'h0, 1, 32'hFF80_0000, 0, ST_OK);
		add_vec(CMD_TO_INT, 32'hFFFF_FFFF, MAXW, 1, 32'hFFFF_FFFF, 0, ST_OK);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_tab[i]) begin
			send_item(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, 1'b1);
			if (dir_tab[i].known) begin
				// swap in the typed-in value so the table itself is checked
				got = pending.pop_back();
				if (got.res !== dir_tab[i].want.res ||
					got.truth !== dir_tab[i].want.truth ||
					got.status !== dir_tab[i].want.status) begin
					$display("%0t row %0d exp res=%h truth=%b st=%0d pred res=%h truth=%b st=%0d",
						$time, i, dir_tab[i].want.res, dir_tab[i].want.truth,
						dir_tab[i].want.status, got.res, got.truth, got.status);
					errors++;
				end
				pending.push_back(dir_tab[i].want);
			end
		end
		in_valid <= 1'b0;
		// drain before the random part
		while (pending.size() != 0) @(negedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - 200) begin
				in_valid <= 1'b0;
				while (pending.size() != 0) @(negedge clk);
				quiet = 1'b1;
			end
			send_item(cmd_t'($urandom_range(0, 15)), pick_word(), pick_word(), !quiet);
		end
		in_valid <= 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== fixed_point_alu.f =====
rtl/fxa_pkg.sv
rtl/fxa_div.sv
rtl/fixed_point_alu.sv
verif/tb_fixed_point_alu.sv
